// File: sv/nta_pkg.sv
// shared types and constants of the neighbor table with aging
`timescale 1ns / 1ps
`default_nettype none
package nta_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [15:0] AGE_LIMIT_RST   = 16'd320;
	localparam logic [7:0]  NO_NEIGHBOR_RST = 8'd90;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_PURGE  = 1'b1;

	localparam logic REG_AGE_LIMIT   = 1'b0;
	localparam logic REG_NO_NEIGHBOR = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [15:0] sender_id;
		logic [7:0]  distance;
		logic [7:0]  reported_count;
		logic [7:0]  reported_state;
		logic [31:0] tick;
	} cmd_t;

	typedef struct packed {
		logic [4:0] neighbor_count;
		logic [7:0] nearest_distance;
		logic [7:0] nearest_even_slot;
		logic [7:0] nearest_odd_slot;
		logic       both_sides_seen;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] stamp;
		logic [7:0]  distance;
		logic [7:0]  cnt;
		logic [7:0]  st;
	} entry_t;

	typedef struct packed {
		logic [7:0] all_min;
		logic [7:0] even_min;
		logic [7:0] odd_min;
		logic       seen_even;
		logic       seen_odd;
	} scan_t;

endpackage
`default_nettype wire

// File: sv/neighbor_table_with_aging.sv
// top level of the neighbor table with aging: control, config port and slot row
//
// channel  | ports                                  | timing
// ---------+----------------------------------------+--------------------------------
// command  | start, busy, cmd                       | word taken when start & !busy
// result   | done, rsp                              | one-cycle strobe, no back-pressure
// config   | psel penable pwrite paddr pwdata prdata| apb, write on access cycle
//
// record: the time from start to done is set by the token walking the slot row
// purge: each valid slot is walked from the top down first, then the same scan
// one word at a time; busy stays high from the accepting edge until the done cycle
// reset clears the count and control; slot contents stay undefined until written
// done is never held off: the result is valid in its strobe cycle only
`timescale 1ns / 1ps
`default_nettype none
module neighbor_table_with_aging #(
	parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  nta_pkg::cmd_t                  cmd,
	output logic                           done,
	output nta_pkg::rsp_t                  rsp,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [nta_pkg::PADDR_W-1:0]    paddr,
	input  wire  [nta_pkg::PDATA_W-1:0]    pwdata,
	output logic [nta_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import nta_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PURGE = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] walk_q;
	logic [31:0]   tick_q;
	logic          scan_go_q;
	logic          done_q;
	rsp_t          rsp_q;
	logic [15:0]   age_limit_q;
	logic [7:0]    nbr_dist_q;

	entry_t              rd      [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] we_vec;
	logic                tok_c   [TABLE_DEPTH+1];
	scan_t               acc_c   [TABLE_DEPTH+1];

	logic          accept;
	logic          cfg_wr;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] miss_slot;
	logic [31:0]   age;
	logic          aged;
	entry_t        wdata;
	entry_t        new_entry;

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_AGE_LIMIT:   prdata = {16'b0, age_limit_q};
			REG_NO_NEIGHBOR: prdata = {24'b0, nbr_dist_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RST;
			nbr_dist_q  <= NO_NEIGHBOR_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_AGE_LIMIT:   age_limit_q <= pwdata[15:0];
				REG_NO_NEIGHBOR: nbr_dist_q  <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	assign last_idx  = count_q[IW-1:0] - IW'(1);
	assign miss_slot = (count_q < DEPTH_C) ? count_q[IW-1:0] : LAST_SLOT;
	assign age       = tick_q - rd[walk_q].stamp;
	assign aged      = age > {16'b0, age_limit_q};

	always_comb begin
		new_entry.id       = cmd.sender_id;
		new_entry.stamp    = cmd.tick;
		new_entry.distance = cmd.distance;
		new_entry.cnt      = cmd.reported_count;
		new_entry.st       = cmd.reported_state;
	end

	assign wdata = (state_q == ST_IDLE) ? new_entry : rd[last_idx];

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid_vec[i] = CW'(i) < count_q;
			hit_vec[i]   = valid_vec[i] && (rd[i].id == cmd.sender_id);
		end
	end

	always_comb begin
		we_vec = '0;
		if (accept && cmd.operation == OP_RECORD) begin
			if (|hit_vec) begin
				we_vec = hit_vec;
			end else begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					we_vec[i] = IW'(i) == miss_slot;
				end
			end
		end else if (state_q == ST_PURGE && aged) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				we_vec[i] = IW'(i) == walk_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			walk_q    <= '0;
			scan_go_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			scan_go_q <= 1'b0;
			done_q    <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.operation == OP_RECORD) begin
							if (!(|hit_vec) && count_q < DEPTH_C) begin
								count_q <= count_q + CW'(1);
							end
							state_q   <= ST_SCAN;
							scan_go_q <= 1'b1;
						end else if (count_q == '0) begin
							state_q   <= ST_SCAN;
							scan_go_q <= 1'b1;
						end else begin
							state_q <= ST_PURGE;
							walk_q  <= last_idx;
						end
					end
				end
				ST_PURGE: begin
					if (aged) begin
						count_q <= count_q - CW'(1);
					end
					if (walk_q == '0) begin
						state_q   <= ST_SCAN;
						scan_go_q <= 1'b1;
					end else begin
						walk_q <= walk_q - IW'(1);
					end
				end
				ST_SCAN: begin
					if (tok_c[TABLE_DEPTH]) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= cmd.tick;
		end
		if (state_q == ST_SCAN && tok_c[TABLE_DEPTH]) begin
			rsp_q.neighbor_count    <= 5'(count_q);
			rsp_q.nearest_distance  <= acc_c[TABLE_DEPTH].all_min;
			rsp_q.nearest_even_slot <= acc_c[TABLE_DEPTH].even_min;
			rsp_q.nearest_odd_slot  <= acc_c[TABLE_DEPTH].odd_min;
			rsp_q.both_sides_seen   <= acc_c[TABLE_DEPTH].seen_even
				&& acc_c[TABLE_DEPTH].seen_odd;
		end
	end

	assign tok_c[0]           = scan_go_q;
	assign acc_c[0].all_min   = nbr_dist_q;
	assign acc_c[0].even_min  = nbr_dist_q;
	assign acc_c[0].odd_min   = nbr_dist_q;
	assign acc_c[0].seen_even = 1'b0;
	assign acc_c[0].seen_odd  = 1'b0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
		nta_slot #(
			.ODD_SLOT(g % 2 == 1)
		) u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.we     (we_vec[g]),
			.wdata  (wdata),
			.valid  (valid_vec[g]),
			.rd     (rd[g]),
			.tok_in (tok_c[g]),
			.acc_in (acc_c[g]),
			.tok_out(tok_c[g+1]),
			.acc_out(acc_c[g+1])
		);
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("slot count above table depth");

	a_walk_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PURGE |-> CW'(walk_q) < count_q)
		else $error("purge walk outside valid slots");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("sender id held in more than one slot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE && $past(state_q) == ST_SCAN)
		else $error("result strobe outside end of scan");

	a_scan_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.operation == OP_RECORD |=> state_q == ST_SCAN && scan_go_q)
		else $error("record word did not start the scan");

endmodule
`default_nettype wire

// File: sv/nta_slot.sv
// one table slot: entry storage and one step of the distance scan chain
`timescale 1ns / 1ps
`default_nettype none
module nta_slot #(
	parameter bit ODD_SLOT = 1'b0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              we,
	input  nta_pkg::entry_t  wdata,
	input  wire              valid,
	output nta_pkg::entry_t  rd,
	input  wire              tok_in,
	input  nta_pkg::scan_t   acc_in,
	output logic             tok_out,
	output nta_pkg::scan_t   acc_out
);
	import nta_pkg::*;

	entry_t entry_q;
	logic   tok_q;
	scan_t  acc_q;
	scan_t  acc_nxt;

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= wdata;
		end
	end

	always_comb begin
		acc_nxt = acc_in;
		if (valid) begin
			if (entry_q.distance < acc_in.all_min) begin
				acc_nxt.all_min = entry_q.distance;
			end
			if (ODD_SLOT) begin
				if (entry_q.distance < acc_in.odd_min) begin
					acc_nxt.odd_min = entry_q.distance;
				end
			end else begin
				if (entry_q.distance < acc_in.even_min) begin
					acc_nxt.even_min = entry_q.distance;
				end
			end
			if (entry_q.id[0]) begin
				acc_nxt.seen_odd = 1'b1;
			end else begin
				acc_nxt.seen_even = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_nxt;
	end

	assign rd      = entry_q;
	assign tok_out = tok_q;
	assign acc_out = acc_q;

endmodule
`default_nettype wire
